>>> design/ccea_pkg.sv
// Package for the calorimeter cell energy accumulator.
// Types, sizes and codes shared by the front end, queue and back end.
`default_nettype none
package ccea_pkg;
   localparam int BarrelSegments = 16;
   localparam int BarrelModules  = 64;
   localparam int IonSide        = 16;
   localparam int ElectronSide   = 16;
   localparam int BarrelCells    = BarrelSegments * BarrelModules;
   localparam int IonCells       = IonSide * IonSide;
   localparam int ElectronCells  = ElectronSide * ElectronSide;
   localparam int AllCells       = BarrelCells + IonCells + ElectronCells;
   localparam int AddrW          = $clog2(AllCells);
   localparam int PosW           = $clog2(AllCells + 1);

   localparam logic [1:0] ACT_DEPOSIT = 2'd0;
   localparam logic [1:0] ACT_SUMMARY = 2'd1;
   localparam logic [1:0] ACT_FETCH   = 2'd2;

   localparam logic [1:0] KIND_SUMMARY = 2'd0;
   localparam logic [1:0] KIND_CELL    = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   localparam logic [1:0] CSR_SHASHLIK_GAIN = 2'd0;
   localparam logic [1:0] CSR_ELECTRON_GAIN = 2'd1;
   localparam logic [1:0] CSR_LAYER_LIMIT   = 2'd2;

   // classified command from front to back
   typedef struct packed {
      logic [1:0]       op;       // ACT_* code
      logic             cell_ok;  // deposit hits a cell
      logic [1:0]       region;
      logic [AddrW-1:0] addr;     // flat cell address
      logic [23:0]      energy;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  region;
      logic [3:0]  segment;
      logic [5:0]  module_idx;
      logic [31:0] energy;
      logic [10:0] block_count;
      logic [10:0] barrel_count;
      logic [8:0]  ion_count;
      logic [8:0]  electron_count;
      logic [39:0] total;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_MUL, ST_OUT
   } back_state_type;
endpackage
`default_nettype wire

>>> design/ccea_front.sv
// Front end: takes request words, checks limits, builds flat cell addresses.
// Depends on ccea_pkg.
`default_nettype none
module ccea_front import ccea_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [1:0]  action,
   input  wire logic [1:0]  region,
   input  wire logic [3:0]  segment,
   input  wire logic [5:0]  module_idx,
   input  wire logic [7:0]  layer,
   input  wire logic [23:0] energy,
   input  wire logic [7:0]  layer_limit,
   output logic             cmd_valid,
   input  wire logic        cmd_ready,
   output cmd_type          cmd
);
   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    below;

   assign in_ready  = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;
   assign below     = layer < layer_limit;

   // classify one word
   always_comb begin
      cmd_in         = '0;
      cmd_in.op      = action;
      cmd_in.region  = region;
      cmd_in.energy  = energy;
      case (region)
         2'd0: begin
            cmd_in.cell_ok = below && (32'(segment) < BarrelSegments)
                             && (32'(module_idx) < BarrelModules);
            cmd_in.addr = AddrW'(32'(segment) * BarrelModules + 32'(module_idx));
         end
         2'd1: begin
            cmd_in.cell_ok = below && (32'(segment) < IonSide)
                             && (32'(module_idx) < IonSide);
            cmd_in.addr = AddrW'(BarrelCells + 32'(segment) * IonSide
                                 + 32'(module_idx));
         end
         2'd2: begin
            cmd_in.cell_ok = (32'(segment) < ElectronSide)
                             && (32'(module_idx) < ElectronSide);
            cmd_in.addr = AddrW'(BarrelCells + IonCells
                                 + 32'(segment) * ElectronSide + 32'(module_idx));
         end
         default: cmd_in.cell_ok = 1'b0;
      endcase
   end

   // action 3 is dropped here
   always_comb begin
      valid_in = valid_ff && !cmd_ready;
      if (in_valid && in_ready && action != 2'd3) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (in_valid && in_ready) cmd_ff <= cmd_in;
   end
endmodule
`default_nettype wire

>>> design/ccea_queue.sv
// Four-entry command queue between front and back end.
// Depends on ccea_pkg.
`default_nettype none
module ccea_queue import ccea_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_valid,
   output logic         wr_ready,
   input  wire cmd_type wr_data,
   output logic         rd_valid,
   input  wire logic    rd_ready,
   output cmd_type      rd_data
);
   cmd_type    mem [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_ready = cnt_ff != 3'd4;
   assign rd_valid = cnt_ff != 3'd0;
   assign rd_data  = mem[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

>>> design/ccea_back.sv
// Back end: cell sum memory, counters, clearing pass, scan and gain multiply.
// Depends on ccea_pkg.
`default_nettype none
module ccea_back import ccea_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   output logic             cmd_ready,
   input  wire cmd_type     cmd,
   input  wire logic [23:0] shashlik_gain,
   input  wire logic [23:0] electron_gain,
   output logic             out_valid,
   input  wire logic        out_ready,
   output rsp_type          out_data,
   output logic             clearing
);
   logic [31:0]    sums [AllCells];
   back_state_type state_ff, state_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [AddrW-1:0] clr_ff;
   logic           clr_busy_ff;
   logic [39:0]    total_ff, total_in;
   logic [10:0]    nz_ff, nzb_ff;
   logic [8:0]     nzi_ff, nze_ff;
   logic [31:0]    rd_ff;
   logic [AddrW-1:0] cur_ff;
   logic [55:0]    prod_ff;
   logic [23:0]    gain;
   logic           ovalid_ff;
   rsp_type        odata_ff, odata_in;
   // deposit pipeline: stage 1 reads, stage 2 writes
   logic           d1_ff;
   cmd_type        c1_ff;
   logic [31:0]    old_val, sum_new;
   logic [32:0]    sum_wide;
   logic           hazard;
   logic           take, do_dep, scan_wr;
   logic [40:0]    tot_wide;

   assign clearing  = clr_busy_ff;
   assign out_valid = ovalid_ff;
   assign out_data  = odata_ff;
   // a summary is held back while a deposit is in the write stage so the counters are settled
   assign cmd_ready = !clr_busy_ff && state_ff == ST_IDLE && !ovalid_ff
                      && !(cmd_valid && d1_ff && cmd.op == ACT_SUMMARY);
   assign take      = cmd_valid && cmd_ready;
   assign do_dep    = take && cmd.op == ACT_DEPOSIT;

   // read-modify-write with forwarding from the write stage
   assign hazard   = d1_ff && c1_ff.cell_ok && take && cmd.cell_ok
                     && cmd.addr == c1_ff.addr;
   assign old_val  = rd_ff;
   assign sum_wide = {1'b0, old_val} + {9'd0, c1_ff.energy};
   assign sum_new  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
   assign tot_wide = {1'b0, total_ff} + {17'd0, cmd.energy};
   assign gain     = (32'(cur_ff) >= BarrelCells + IonCells) ? electron_gain
                                                              : shashlik_gain;
   assign scan_wr  = state_ff == ST_SCAN_CHK && rd_ff != 32'd0;

   // next state of the scan sequencer
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && cmd.op == ACT_FETCH) state_in = ST_SCAN_RD;
            if (take && cmd.op == ACT_SUMMARY) begin
               pos_in = '0; state_in = ST_OUT;
            end
         end
         ST_SCAN_RD:
            if (32'(pos_ff) >= AllCells) state_in = ST_OUT;
            else begin
               state_in = ST_SCAN_CHK; pos_in = pos_ff + 1'b1;
            end
         ST_SCAN_CHK: state_in = (rd_ff != 32'd0) ? ST_MUL : ST_SCAN_RD;
         ST_MUL:      state_in = ST_OUT;
         ST_OUT:      state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // result word
   always_comb begin
      logic [39:0] sh;
      sh       = prod_ff[55:16];
      odata_in = '0;
      case (state_ff)
         ST_IDLE: begin
            odata_in.kind           = KIND_SUMMARY;
            odata_in.block_count    = nz_ff;
            odata_in.barrel_count   = nzb_ff;
            odata_in.ion_count      = nzi_ff;
            odata_in.electron_count = nze_ff;
            odata_in.total          = total_ff;
         end
         ST_MUL: begin
            odata_in.kind = KIND_CELL;
            if (32'(cur_ff) < BarrelCells) begin
               odata_in.region     = 2'd0;
               odata_in.segment    = 4'(32'(cur_ff) / BarrelModules);
               odata_in.module_idx = 6'(32'(cur_ff) % BarrelModules);
            end else if (32'(cur_ff) < BarrelCells + IonCells) begin
               odata_in.region     = 2'd1;
               odata_in.segment    = 4'((32'(cur_ff) - BarrelCells) / IonSide);
               odata_in.module_idx = 6'((32'(cur_ff) - BarrelCells) % IonSide);
            end else begin
               odata_in.region     = 2'd2;
               odata_in.segment    = 4'((32'(cur_ff) - BarrelCells - IonCells)
                                        / ElectronSide);
               odata_in.module_idx = 6'((32'(cur_ff) - BarrelCells - IonCells)
                                        % ElectronSide);
            end
            odata_in.energy = (sh[39:32] != 8'd0) ? 32'hFFFF_FFFF : sh[31:0];
         end
         default: odata_in.kind = KIND_DONE;
      endcase
   end

   // memory: clear pass, deposit write, scan clear; registered read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) sums[clr_ff] <= '0;
      else if (d1_ff && c1_ff.cell_ok) sums[c1_ff.addr] <= sum_new;
      else if (scan_wr) sums[cur_ff] <= '0;
      if (do_dep && cmd.cell_ok) rd_ff <= hazard ? sum_new : sums[cmd.addr];
      else if (state_ff == ST_SCAN_RD && 32'(pos_ff) < AllCells) begin
         rd_ff  <= sums[AddrW'(pos_ff)];
         cur_ff <= AddrW'(pos_ff);
      end
      if (state_ff == ST_SCAN_CHK) prod_ff <= rd_ff * gain;
      c1_ff <= cmd;
      if (state_in == ST_OUT && state_ff != ST_OUT) odata_ff <= odata_in;
      if (state_ff == ST_MUL) odata_ff <= odata_in;
   end

   // control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1; clr_ff <= '0;
         state_ff <= ST_IDLE; pos_ff <= '0; d1_ff <= 1'b0; ovalid_ff <= 1'b0;
         total_ff <= '0; nz_ff <= '0; nzb_ff <= '0; nzi_ff <= '0; nze_ff <= '0;
      end else begin
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (32'(clr_ff) == AllCells - 1) clr_busy_ff <= 1'b0;
         end
         state_ff <= state_in;
         pos_ff   <= pos_in;
         d1_ff    <= do_dep && cmd.cell_ok;
         if (state_ff == ST_OUT) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
         if (do_dep) total_ff <= tot_wide[40] ? '1 : tot_wide[39:0];
         if (d1_ff && c1_ff.cell_ok && old_val == 32'd0 && sum_new != 32'd0) begin
            if (nz_ff != '1) nz_ff <= nz_ff + 1'b1;
            case (c1_ff.region)
               2'd0:    if (nzb_ff != '1) nzb_ff <= nzb_ff + 1'b1;
               2'd1:    if (nzi_ff != '1) nzi_ff <= nzi_ff + 1'b1;
               default: if (nze_ff != '1) nze_ff <= nze_ff + 1'b1;
            endcase
         end
         if (take && cmd.op == ACT_SUMMARY) begin
            total_ff <= '0; nz_ff <= '0; nzb_ff <= '0; nzi_ff <= '0; nze_ff <= '0;
         end
      end
   end
endmodule
`default_nettype wire

>>> design/calorimeter_cell_energy_accumulator_core.sv
// Top level of the calorimeter cell energy accumulator.
// Depends on ccea_pkg, ccea_front, ccea_queue, ccea_back.
//
// channel | dir | handshake          | payload
// req     | in  | tvalid/tready      | tdata, tuser = action
// rsp     | out | tvalid/tready      | tdata, tuser = record_kind
// csr     | in  | we                 | index, wdata
//
// Deposits: one per cycle through the read/write pipeline on the sum memory
// while the back end is idle, not clearing and holds no result; a summary
// right behind a deposit is held until the counters are updated. A fetch reads
// a cell at a time on the single read port. After reset a clearing pass over
// all 1536 cells runs before the back end takes a word. The queue lets the
// front keep taking words while the back end scans or waits on rsp_tready.
`default_nettype none
module calorimeter_cell_energy_accumulator_core import ccea_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // region[1:0], segment_index[5:2], module_index[11:6], layer_index[19:12],
   // deposit_energy[43:20], zero fill
   input  wire logic [47:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // cell_region[1:0], cell_segment[5:2], cell_module[11:6], cell_energy[43:12],
   // block_count[54:44], barrel_count[65:55], ion_count[74:66],
   // electron_count[83:75], total_energy[123:84], zero fill
   output logic [127:0]     rsp_tdata,
   // record_kind[1:0]
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   logic [23:0] shashlik_gain_ff, electron_gain_ff;
   logic [7:0]  layer_limit_ff;
   logic        f_valid, f_ready, q_valid, q_ready, clearing;
   cmd_type     f_cmd, q_cmd;
   rsp_type     r;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shashlik_gain_ff <= 24'd65536;
         electron_gain_ff <= 24'd65536;
         layer_limit_ff   <= 8'd255;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHASHLIK_GAIN: shashlik_gain_ff <= csr_wdata;
            CSR_ELECTRON_GAIN: electron_gain_ff <= csr_wdata;
            CSR_LAYER_LIMIT:   layer_limit_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   ccea_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .action(req_tuser), .region(req_tdata[1:0]), .segment(req_tdata[5:2]),
      .module_idx(req_tdata[11:6]), .layer(req_tdata[19:12]),
      .energy(req_tdata[43:20]), .layer_limit(layer_limit_ff),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   ccea_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
   );

   ccea_back u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .shashlik_gain(shashlik_gain_ff), .electron_gain(electron_gain_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(r),
      .clearing(clearing)
   );

   assign rsp_tuser = r.kind;
   assign rsp_tdata = {4'd0, r.total, r.electron_count, r.ion_count,
                       r.barrel_count, r.block_count, r.energy,
                       r.module_idx, r.segment, r.region};

   // no command leaves the queue during the clearing pass
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_ready) else $error("command taken while clearing");
   // a result holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   // a cell record never reports a region outside the three
   a_cell_region: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_CELL |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad region");
endmodule
`default_nettype wire
